>>> hw/rtl/ellipse_stroke_pixel_blend_defines.svh
// Assertion macros shared by the ellipse stroke blend RTL.
// Included by every file that carries concurrent assertions.
`ifndef ELLIPSE_STROKE_PIXEL_BLEND_DEFINES_SVH
`define ELLIPSE_STROKE_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESPB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/espb_pkg.sv
// Shared types and constants of the ellipse stroke pixel blend.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package espb_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 32;

  // Unsigned magnitudes after rotation and the products built from them.
  localparam int unsigned AbsW   = 8;
  localparam int unsigned SqW    = 16;
  localparam int unsigned Maj2W  = 14;
  localparam int unsigned Min2W  = 12;
  localparam int unsigned LimW   = 26;
  localparam int unsigned UTermW = 28;
  localparam int unsigned VTermW = 29;
  localparam int unsigned DistW  = 30;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_VERT = 2'd2,
    DIR_ANTI = 2'd3
  } dir_e;

  // Colour data that rides alongside the geometry.
  typedef struct packed {
    logic [7:0]  opacity;
    logic [7:0]  op_third;
    logic [7:0]  op_two_thirds;
    logic [15:0] under;
    logic [15:0] color;
  } side_t;

  typedef struct packed {
    logic [AbsW-1:0]  abs_u;
    logic [AbsW-1:0]  abs_v;
    logic [Maj2W-1:0] maj2;
    logic [Min2W-1:0] min2;
    side_t            side;
  } geo_t;

  typedef struct packed {
    logic        covered;
    logic [7:0]  alpha;
    logic [15:0] under;
    logic [15:0] color;
  } mix_t;

endpackage

>>> hw/rtl/espb_in_if.sv
// Input channel of the ellipse stroke blend: one pixel and its stroke per beat.
// Depends on espb_pkg.
`timescale 1ns / 1ps

interface espb_in_if;
  import espb_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic [5:0]        radius;
  logic [1:0]        direction;
  logic [15:0]       under_pixel;
  logic [15:0]       brush_color;
  logic [7:0]        opacity;

  modport source (
    output valid, dx, dy, radius, direction, under_pixel, brush_color, opacity,
    input  ready
  );

  modport sink (
    input  valid, dx, dy, radius, direction, under_pixel, brush_color, opacity,
    output ready
  );

endinterface

>>> hw/rtl/espb_out_if.sv
// Output channel of the ellipse stroke blend: one blended pixel per beat.
// Depends on espb_pkg.
`timescale 1ns / 1ps

interface espb_out_if;
  import espb_pkg::*;

  logic        valid;
  logic        ready;
  logic        covered;
  logic [15:0] pixel_out;

  modport source (
    output valid, covered, pixel_out,
    input  ready
  );

  modport sink (
    input  valid, covered, pixel_out,
    output ready
  );

endinterface

>>> hw/rtl/ellipse_stroke_pixel_blend.sv
// Ellipse stroke pixel blend, top level.
// Six register stages. Throughput: one beat per cycle while the output accepts beats.
// Backpressure stalls only the stages that are full, so bubbles are squeezed out.
// Reset (asynchronous, active low) clears every stage valid bit; the data registers are not reset.
`timescale 1ns / 1ps

module ellipse_stroke_pixel_blend #(
  parameter int unsigned MaxRadius = espb_pkg::MAX_RADIUS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  espb_in_if.sink    in_i,
  espb_out_if.source out_o
);
  import espb_pkg::*;
  `include "ellipse_stroke_pixel_blend_defines.svh"

  logic rot_valid, rot_ready;
  geo_t rot_geo;
  logic dist_valid, dist_ready;
  mix_t dist_mix;

  espb_rotate #(
    .MaxRadius (MaxRadius)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .dx_i        (in_i.dx),
    .dy_i        (in_i.dy),
    .radius_i    (in_i.radius),
    .direction_i (in_i.direction),
    .under_i     (in_i.under_pixel),
    .color_i     (in_i.brush_color),
    .opacity_i   (in_i.opacity),
    .valid_o     (rot_valid),
    .ready_i     (rot_ready),
    .geo_o       (rot_geo)
  );

  espb_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .geo_i   (rot_geo),
    .valid_o (dist_valid),
    .ready_i (dist_ready),
    .mix_o   (dist_mix)
  );

  espb_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dist_valid),
    .ready_o   (dist_ready),
    .mix_i     (dist_mix),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .covered_o (out_o.covered),
    .pixel_o   (out_o.pixel_out)
  );

  // The pipeline refuses a beat only when every stage is full behind a stalled output.
  `ESPB_ASSERT_IMP(a_stall_from_sink, clk_i, rst_ni, !in_i.ready,
                   out_o.valid && !out_o.ready, "input stalled without output backpressure")
  `ESPB_ASSERT_NXT(a_stall_keeps_result, clk_i, rst_ni, !in_i.ready,
                   out_o.valid, "result lost while the input was stalled")

endmodule

>>> hw/rtl/espb_rotate.sv
// First pipeline stage: radius clamp, rotation of the offset, axis squares
// and the alpha tier candidates. Depends on espb_pkg.
`timescale 1ns / 1ps

module espb_rotate #(
  parameter int unsigned MaxRadius = espb_pkg::MAX_RADIUS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [7:0]  dx_i,
  input  logic signed [7:0]  dy_i,
  input  logic [5:0]         radius_i,
  input  logic [1:0]         direction_i,
  input  logic [15:0]        under_i,
  input  logic [15:0]        color_i,
  input  logic [7:0]         opacity_i,
  output logic               valid_o,
  input  logic               ready_i,
  output espb_pkg::geo_t     geo_o
);
  import espb_pkg::*;

  // Multiply by 181/256 and truncate toward zero.
  function automatic logic signed [8:0] scale_diag(input logic signed [8:0] s);
    logic signed [17:0] p;
    p = 18'(s) * 18'sd181;
    if (p < 0) begin
      p = p + 18'sd255;
    end
    return p[16:8];
  endfunction

  logic              valid_q;
  geo_t              geo_d, geo_q;
  logic [5:0]        radius_sat;
  logic [6:0]        major;
  logic [5:0]        minor;
  logic signed [8:0] sum_s, dif_s, diag_p, diag_m;
  logic signed [8:0] u_s, v_s;

  always_comb begin
    if ({1'b0, radius_i} > 7'(MaxRadius)) begin
      radius_sat = 6'(MaxRadius);
    end else begin
      radius_sat = radius_i;
    end
    major = {radius_sat, 1'b0};
    minor = (radius_sat == 6'd0) ? 6'd1 : radius_sat;

    sum_s  = 9'(dx_i) + 9'(dy_i);
    dif_s  = 9'(dx_i) - 9'(dy_i);
    diag_p = scale_diag(sum_s);
    diag_m = scale_diag(dif_s);

    case (dir_e'(direction_i))
      DIR_HORZ: begin
        u_s = 9'(dx_i);
        v_s = 9'(dy_i);
      end
      DIR_DIAG: begin
        u_s = diag_p;
        v_s = diag_m;
      end
      DIR_VERT: begin
        u_s = 9'(dy_i);
        v_s = 9'(dx_i);
      end
      DIR_ANTI: begin
        // Truncation toward zero is symmetric, so (dy-dx) scales to -diag_m.
        u_s = -diag_m;
        v_s = diag_p;
      end
      default: begin
        u_s = 9'(dx_i);
        v_s = 9'(dy_i);
      end
    endcase

    geo_d.abs_u = u_s[8] ? AbsW'(-u_s) : u_s[AbsW-1:0];
    geo_d.abs_v = v_s[8] ? AbsW'(-v_s) : v_s[AbsW-1:0];
    geo_d.maj2  = Maj2W'(major) * Maj2W'(major);
    geo_d.min2  = Min2W'(minor) * Min2W'(minor);

    // x/3 as (x*171) >> 9, exact for x below 512.
    geo_d.side.opacity       = opacity_i;
    geo_d.side.op_third      = 8'((17'(opacity_i) * 17'd171) >> 9);
    geo_d.side.op_two_thirds = 8'((17'({opacity_i, 1'b0}) * 17'd171) >> 9);
    geo_d.side.under         = under_i;
    geo_d.side.color         = color_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      geo_q <= geo_d;
    end
  end

  assign valid_o = valid_q;
  assign geo_o   = geo_q;

endmodule

>>> hw/rtl/espb_dist.sv
// Ellipse test over three stages: squares, weighted terms, then the
// distance sum compared against the limit and its tiers. Depends on espb_pkg.
`timescale 1ns / 1ps

module espb_dist (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  espb_pkg::geo_t geo_i,
  output logic           valid_o,
  input  logic           ready_i,
  output espb_pkg::mix_t mix_o
);
  import espb_pkg::*;

  // Stage two: squares of the rotated offset and the ellipse limit.
  logic              v2_q, rdy2;
  logic [SqW-1:0]    u2_q, v2sq_q;
  logic [Maj2W-1:0]  maj2_q;
  logic [Min2W-1:0]  min2_q;
  logic [LimW-1:0]   lim2_q;
  side_t             side2_q;

  // Stage three: axis-weighted terms.
  logic              v3_q, rdy3;
  logic [UTermW-1:0] uterm_q;
  logic [VTermW-1:0] vterm_q;
  logic [LimW-1:0]   lim3_q;
  side_t             side3_q;

  // Stage four: coverage and alpha.
  logic              v4_q, rdy4;
  mix_t              mix_d, mix_q;
  logic [DistW-1:0]  dist_sum;
  logic [LimW+1:0]   lim_x3;
  logic [LimW-1:0]   lim_q34, lim_half;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      u2_q    <= SqW'(geo_i.abs_u) * SqW'(geo_i.abs_u);
      v2sq_q  <= SqW'(geo_i.abs_v) * SqW'(geo_i.abs_v);
      maj2_q  <= geo_i.maj2;
      min2_q  <= geo_i.min2;
      lim2_q  <= LimW'(geo_i.maj2) * LimW'(geo_i.min2);
      side2_q <= geo_i.side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      uterm_q <= UTermW'(u2_q) * UTermW'(min2_q);
      vterm_q <= VTermW'(v2sq_q) * VTermW'(maj2_q);
      lim3_q  <= lim2_q;
      side3_q <= side2_q;
    end
  end

  always_comb begin
    dist_sum = DistW'(uterm_q) + DistW'(vterm_q);
    lim_x3   = (LimW+2)'(lim3_q) + (LimW+2)'({lim3_q, 1'b0});
    lim_q34  = LimW'(lim_x3 >> 2);
    lim_half = lim3_q >> 1;

    mix_d.covered = (dist_sum <= DistW'(lim3_q));
    mix_d.under   = side3_q.under;
    mix_d.color   = side3_q.color;
    // An uncovered pixel blends with zero alpha, which returns it unchanged.
    if (!mix_d.covered) begin
      mix_d.alpha = 8'd0;
    end else if (dist_sum > DistW'(lim_q34)) begin
      mix_d.alpha = side3_q.op_third;
    end else if (dist_sum > DistW'(lim_half)) begin
      mix_d.alpha = side3_q.op_two_thirds;
    end else begin
      mix_d.alpha = side3_q.opacity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      mix_q <= mix_d;
    end
  end

  assign valid_o = v4_q;
  assign mix_o   = mix_q;

endmodule

>>> hw/rtl/espb_blend.sv
// Per-channel alpha blend of byte-swapped RGB565 with rounded division by 255,
// over two stages whose second is the output register. Depends on espb_pkg.
`timescale 1ns / 1ps

module espb_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  espb_pkg::mix_t mix_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           covered_o,
  output logic [15:0]    pixel_o
);
  import espb_pkg::*;
  `include "ellipse_stroke_pixel_blend_defines.svh"

  function automatic logic [13:0] mix_num(input logic [5:0] a, input logic [5:0] b,
                                          input logic [7:0] alpha);
    return 14'(a) * 14'(8'd255 - alpha) + 14'(b) * 14'(alpha) + 14'd127;
  endfunction

  // floor(n / 255), exact for n up to 16192, the largest numerator a channel gives.
  function automatic logic [5:0] div255(input logic [13:0] n);
    logic [13:0] t;
    t = n + (n >> 8) + 14'd1;
    return 6'(t >> 8);
  endfunction

  logic        v5_q, rdy5, v6_q, rdy6;
  mix_t        mix5_q;
  logic [15:0] under_sw, color_sw;
  logic [13:0] num_r_q, num_g_q, num_b_q;
  logic [5:0]  res_r, res_g, res_b;
  logic [15:0] packed_rgb;
  logic        covered_q;
  logic [15:0] pixel_q;

  assign rdy6    = !v6_q || ready_i;
  assign rdy5    = !v5_q || rdy6;
  assign ready_o = rdy5;

  assign under_sw = {mix_i.under[7:0], mix_i.under[15:8]};
  assign color_sw = {mix_i.color[7:0], mix_i.color[15:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) begin
        v5_q <= valid_i;
      end
      if (rdy6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && valid_i) begin
      mix5_q  <= mix_i;
      num_r_q <= mix_num({1'b0, under_sw[15:11]}, {1'b0, color_sw[15:11]}, mix_i.alpha);
      num_g_q <= mix_num(under_sw[10:5], color_sw[10:5], mix_i.alpha);
      num_b_q <= mix_num({1'b0, under_sw[4:0]}, {1'b0, color_sw[4:0]}, mix_i.alpha);
    end
  end

  always_comb begin
    res_r      = div255(num_r_q);
    res_g      = div255(num_g_q);
    res_b      = div255(num_b_q);
    packed_rgb = {res_r[4:0], res_g, res_b[4:0]};
  end

  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      covered_q <= mix5_q.covered;
      pixel_q   <= {packed_rgb[7:0], packed_rgb[15:8]};
    end
  end

  assign valid_o   = v6_q;
  assign covered_o = covered_q;
  assign pixel_o   = pixel_q;

  `ESPB_ASSERT_NXT(a_uncovered_passes, clk_i, rst_ni, v5_q && rdy6 && !mix5_q.covered,
                   pixel_q == $past(mix5_q.under), "uncovered pixel was altered")
  `ESPB_ASSERT_NXT(a_opaque_takes_color, clk_i, rst_ni, v5_q && rdy6 && (mix5_q.alpha == 8'd255),
                   pixel_q == $past(mix5_q.color), "opaque blend differs from stroke colour")

endmodule
